FILE: hdl/eds_pkg.sv
package eds_pkg;

    // command codes on the mode field
    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_REMOVE  = 3'd1;
    localparam logic [2:0] MODE_ADVANCE = 3'd2;
    localparam logic [2:0] MODE_FIRE    = 3'd3;
    localparam logic [2:0] MODE_SWEEP   = 3'd4;

    // configuration register indexes
    localparam int          CFG_IDX_W  = 1;
    localparam int          CFG_DATA_W = 16;
    localparam logic        REG_EXEMPT = 1'b0;
    localparam logic        REG_HALT   = 1'b1;

    // reset values of the configuration registers
    localparam logic [15:0] EXEMPT_RESET = 16'h3800;
    localparam logic [3:0]  HALT_RESET   = 4'd13;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

endpackage

FILE: hdl/eds_cell.sv
module eds_cell
    import eds_pkg::*;
#(
    parameter int TIME_BITS = 48,
    parameter int LATE_BITS = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic [TIME_BITS-1:0]        deadline_in,
    input  logic                        enabled_in,
    input  logic signed [LATE_BITS-1:0] late_in,
    output logic [TIME_BITS-1:0]        deadline,
    output logic                        enabled,
    output logic signed [LATE_BITS-1:0] late
);

    logic [TIME_BITS-1:0]        deadline_reg;
    logic                        enabled_reg;
    logic signed [LATE_BITS-1:0] late_reg;

    // one slot entry, moves one place along the ring on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= '0;
            enabled_reg  <= 1'b0;
            late_reg     <= '0;
        end
        else if (shift)
        begin
            deadline_reg <= deadline_in;
            enabled_reg  <= enabled_in;
            late_reg     <= late_in;
        end
    end

    assign deadline = deadline_reg;
    assign enabled  = enabled_reg;
    assign late     = late_reg;

endmodule

FILE: hdl/event_deadline_scheduler_unit.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  mode, slot, delay
// out      output     out_valid / out_stall fired_valid .. last
// cfg      input      cfg_we               cfg_index, cfg_data
//
// add, remove, fire and a sweep that fires nothing rotate the slot ring once
// (NUM_SLOTS places) and then load the result word.
// a sweep that fires rotates a second time, handing out the fired words in
// index order; advance and unused modes load the result word without a
// rotation. reset clears every slot, the time and the earliest record.
// out_stall holds the result rotation; a new word waits for the last one.
module event_deadline_scheduler_unit
    import eds_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 48,
    parameter int LATE_BITS = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  mode,
    input  logic [3:0]                  slot,
    input  logic [31:0]                 delay,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        fired_valid,
    output logic [3:0]                  fired_slot,
    output logic                        halt_pending,
    output logic signed [LATE_BITS-1:0] lateness,
    output logic                        next_valid,
    output logic [3:0]                  next_slot,
    output logic [TIME_BITS-1:0]        next_deadline,
    output logic                        due,
    output logic                        last,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);
    localparam logic [TIME_BITS-1:0] LATE_MAG = TIME_BITS'(1) << (LATE_BITS - 1);
    localparam logic signed [LATE_BITS-1:0] LATE_LOW = {1'b1, {(LATE_BITS-1){1'b0}}};

    // saturating time add
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    endfunction

    // deadline minus time, zero when the deadline is not past, clamped to the lateness range
    function automatic logic signed [LATE_BITS-1:0] late_of(input logic [TIME_BITS-1:0] d,
                                                            input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] diff;
        diff = t - d;
        if (d >= t)
            return '0;
        else if (diff >= LATE_MAG)
            return LATE_LOW;
        else
            return LATE_BITS'(-diff);
    endfunction

    state_t state_reg, state_next;

    logic [15:0]          exempt_reg;
    logic [3:0]           halt_reg;
    logic [TIME_BITS-1:0] now_reg;

    // latched command
    logic [2:0]  cmd_reg;
    logic [3:0]  cmd_slot_reg;
    logic [31:0] cmd_delay_reg;

    // ring position and earliest-slot record
    logic [IDX_W-1:0]     cnt_reg;
    logic                 early_found_reg;
    logic [IDX_W-1:0]     early_slot_reg;
    logic [TIME_BITS-1:0] early_dl_reg;
    logic                 best_found_reg;
    logic [IDX_W-1:0]     best_slot_reg;
    logic [TIME_BITS-1:0] best_dl_reg;

    // fire and sweep bookkeeping
    logic                        fire_hit_reg;
    logic [IDX_W-1:0]            fire_slot_reg;
    logic signed [LATE_BITS-1:0] fire_late_reg;
    logic                        sweep_halt_reg;
    logic [NUM_SLOTS-1:0]        fired_mask_reg;

    // output word
    logic                        ov_reg;
    logic                        o_fired_reg;
    logic [3:0]                  o_slot_reg;
    logic                        o_halt_reg;
    logic signed [LATE_BITS-1:0] o_late_reg;
    logic                        o_last_reg;

    // ring
    logic [TIME_BITS-1:0]        c_dl   [NUM_SLOTS];
    logic                        c_en   [NUM_SLOTS];
    logic signed [LATE_BITS-1:0] c_late [NUM_SLOTS];
    logic [TIME_BITS-1:0]        h_dl;
    logic                        h_en;
    logic signed [LATE_BITS-1:0] h_late;
    logic                        shift;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            logic [TIME_BITS-1:0]        dl_in;
            logic                        en_in;
            logic signed [LATE_BITS-1:0] late_in;
            if (g == NUM_SLOTS - 1)
            begin : g_tail
                assign dl_in   = h_dl;
                assign en_in   = h_en;
                assign late_in = h_late;
            end
            else
            begin : g_mid
                assign dl_in   = c_dl[g+1];
                assign en_in   = c_en[g+1];
                assign late_in = c_late[g+1];
            end
            eds_cell #(
                .TIME_BITS (TIME_BITS),
                .LATE_BITS (LATE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (shift),
                .deadline_in (dl_in),
                .enabled_in  (en_in),
                .late_in     (late_in),
                .deadline    (c_dl[g]),
                .enabled     (c_en[g]),
                .late        (c_late[g])
            );
        end
    endgenerate

    // head cell update for the current command
    logic                        at_slot;
    logic                        slot_ok;
    logic                        exempt;
    logic signed [33:0]          off;
    logic [TIME_BITS-1:0]        mag;
    logic                        at_fire;
    logic                        expired;
    logic                        at_halt;
    logic                        sweep_fire;

    always_comb
    begin
        slot_ok    = 32'(cmd_slot_reg) < NUM_SLOTS;
        at_slot    = slot_ok && (32'(cnt_reg) == 32'(cmd_slot_reg));
        exempt     = exempt_reg[cmd_slot_reg];
        off        = $signed({2'b00, cmd_delay_reg}) + 34'(c_late[0]);
        mag        = TIME_BITS'(-off);
        at_fire    = early_found_reg && (cnt_reg == early_slot_reg);
        expired    = c_en[0] && (c_dl[0] <= now_reg);
        at_halt    = 32'(cnt_reg) == 32'(halt_reg);
        sweep_fire = expired && !at_halt;
        h_dl       = c_dl[0];
        h_en       = c_en[0];
        h_late     = c_late[0];
        if (state_reg == ST_SCAN)
        begin
            case (cmd_reg)
                MODE_ADD:
                begin
                    if (at_slot)
                    begin
                        h_en = 1'b1;
                        if (exempt)
                            h_dl = sat_add(now_reg, TIME_BITS'(cmd_delay_reg));
                        else if (!off[33])
                        begin
                            h_dl   = sat_add(now_reg, TIME_BITS'(off[32:0]));
                            h_late = '0;
                        end
                        else
                        begin
                            h_dl   = (now_reg >= mag) ? now_reg - mag : '0;
                            h_late = late_of(h_dl, now_reg);
                        end
                    end
                end
                MODE_REMOVE:
                begin
                    if (at_slot)
                    begin
                        h_en   = 1'b0;
                        h_late = '0;
                    end
                end
                MODE_FIRE:
                begin
                    if (at_fire)
                    begin
                        h_en   = 1'b0;
                        h_late = late_of(c_dl[0], now_reg);
                    end
                end
                MODE_SWEEP:
                begin
                    if (sweep_fire)
                    begin
                        h_en   = 1'b0;
                        h_late = late_of(c_dl[0], now_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // control
    logic out_free;
    logic emit_hit;
    logic emit_go;
    logic [NUM_SLOTS-1:0] mask_rest;

    always_comb
    begin
        out_free  = !ov_reg || !out_stall;
        emit_hit  = fired_mask_reg[cnt_reg];
        emit_go   = !emit_hit || out_free;
        mask_rest = fired_mask_reg & ~((NUM_SLOTS'(2) << cnt_reg) - NUM_SLOTS'(1));
        shift     = (state_reg == ST_SCAN) || ((state_reg == ST_EMIT) && emit_go);
        in_stall  = !((state_reg == ST_IDLE) && !ov_reg);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    if (mode == MODE_ADD || mode == MODE_REMOVE ||
                        mode == MODE_FIRE || mode == MODE_SWEEP)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == IDX_LAST)
                begin
                    if (cmd_reg == MODE_SWEEP &&
                        (fired_mask_reg != '0 || sweep_fire))
                        state_next = ST_EMIT;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go && cnt_reg == IDX_LAST)
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            exempt_reg      <= EXEMPT_RESET;
            halt_reg        <= HALT_RESET;
            now_reg         <= '0;
            cnt_reg         <= '0;
            early_found_reg <= 1'b0;
            early_slot_reg  <= '0;
            early_dl_reg    <= '1;
            best_found_reg  <= 1'b0;
            best_slot_reg   <= '0;
            best_dl_reg     <= '1;
            fire_hit_reg    <= 1'b0;
            sweep_halt_reg  <= 1'b0;
            fired_mask_reg  <= '0;
            ov_reg          <= 1'b0;
            cmd_reg         <= MODE_ADD;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EXEMPT: exempt_reg <= cfg_data;
                    REG_HALT:   halt_reg   <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        cmd_reg        <= mode;
                        cmd_slot_reg   <= slot;
                        cmd_delay_reg  <= delay;
                        cnt_reg        <= '0;
                        best_found_reg <= 1'b0;
                        best_dl_reg    <= '1;
                        fire_hit_reg   <= 1'b0;
                        sweep_halt_reg <= 1'b0;
                        fired_mask_reg <= '0;
                        if (mode == MODE_ADVANCE)
                            now_reg <= sat_add(now_reg, TIME_BITS'(delay));
                    end
                end
                ST_SCAN:
                begin
                    // running minimum, later index wins ties
                    if (h_en && (!best_found_reg || h_dl <= best_dl_reg))
                    begin
                        best_found_reg <= 1'b1;
                        best_slot_reg  <= cnt_reg;
                        best_dl_reg    <= h_dl;
                    end
                    if (cmd_reg == MODE_FIRE && at_fire)
                    begin
                        fire_hit_reg  <= 1'b1;
                        fire_slot_reg <= cnt_reg;
                        fire_late_reg <= h_late;
                    end
                    if (cmd_reg == MODE_SWEEP && expired && at_halt)
                        sweep_halt_reg <= 1'b1;
                    if (cmd_reg == MODE_SWEEP && sweep_fire)
                        fired_mask_reg[cnt_reg] <= 1'b1;
                    if (cnt_reg == IDX_LAST)
                    begin
                        cnt_reg         <= '0;
                        early_found_reg <= 1'b0;
                        early_slot_reg  <= '0;
                        early_dl_reg    <= '1;
                        if (h_en && (!best_found_reg || h_dl <= best_dl_reg))
                        begin
                            early_found_reg <= 1'b1;
                            early_slot_reg  <= cnt_reg;
                            early_dl_reg    <= h_dl;
                        end
                        else if (best_found_reg)
                        begin
                            early_found_reg <= 1'b1;
                            early_slot_reg  <= best_slot_reg;
                            early_dl_reg    <= best_dl_reg;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + IDX_W'(1);
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        cnt_reg <= (cnt_reg == IDX_LAST) ? '0 : cnt_reg + IDX_W'(1);
                        if (emit_hit)
                        begin
                            ov_reg                  <= 1'b1;
                            o_fired_reg             <= 1'b1;
                            o_slot_reg              <= 4'(cnt_reg);
                            o_halt_reg              <= sweep_halt_reg;
                            o_late_reg              <= c_late[0];
                            o_last_reg              <= (mask_rest == '0);
                            fired_mask_reg[cnt_reg] <= 1'b0;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        ov_reg      <= 1'b1;
                        o_fired_reg <= (cmd_reg == MODE_FIRE) && fire_hit_reg;
                        o_slot_reg  <= ((cmd_reg == MODE_FIRE) && fire_hit_reg)
                                       ? 4'(fire_slot_reg) : 4'd0;
                        o_halt_reg  <= (cmd_reg == MODE_SWEEP) && sweep_halt_reg;
                        o_late_reg  <= ((cmd_reg == MODE_FIRE) && fire_hit_reg)
                                       ? fire_late_reg : '0;
                        o_last_reg  <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result word
    assign out_valid     = ov_reg;
    assign fired_valid   = o_fired_reg;
    assign fired_slot    = o_slot_reg;
    assign halt_pending  = o_halt_reg;
    assign lateness      = o_late_reg;
    assign last          = o_last_reg;
    assign next_valid    = early_found_reg;
    assign next_slot     = early_found_reg ? 4'(early_slot_reg) : 4'd0;
    assign next_deadline = early_found_reg ? early_dl_reg : '1;
    assign due           = early_found_reg && (now_reg >= early_dl_reg);

endmodule
